// File: hw/rtl/mls_pkg.sv
// Shared types and constants for the Mobius linear sieve unit.
// Used by the table memories and the top level; depends on nothing else.
package mls_pkg;

    // Width of one integer, one least-prime entry and one listed prime.
    localparam int NUM_W = 18;
    localparam int PROD_W = 2 * NUM_W;
    localparam int LIMIT_MAX = (1 << NUM_W) - 1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ORDER = 2'd1;
    localparam logic [1:0] ST_LIMIT = 2'd2;

    localparam logic [1:0] MU_ZERO = 2'b00;
    localparam logic [1:0] MU_POS  = 2'b01;
    localparam logic [1:0] MU_NEG  = 2'b11;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_WALK_RD,
        S_WALK_MUL,
        S_WALK_CMP,
        S_FINISH
    } state_t;

    // One write into the least-prime and Mobius tables, which share an address.
    typedef struct packed {
        logic             en;
        logic [NUM_W-1:0] addr;
        logic [NUM_W-1:0] factor;
        logic [1:0]       mobius;
    } table_wr_t;

endpackage

// File: hw/rtl/mls_table_mem.sv
// Least-prime-factor and Mobius tables: one write port, one registered read port.
// Depends on mls_pkg for the write command type and the integer width.
module mls_table_mem #(
    parameter int DEPTH = 262144
) (
    input  logic                       aclk,
    input  mls_pkg::table_wr_t         wr,
    input  logic                       rd_en,
    input  logic [mls_pkg::NUM_W-1:0]  rd_addr,
    output logic [mls_pkg::NUM_W-1:0]  rd_factor,
    output logic [1:0]                 rd_mobius
);
    import mls_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    logic [NUM_W-1:0] factor_mem [DEPTH];
    logic [1:0]       mobius_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            factor_mem[wr.addr[ADDR_W-1:0]] <= wr.factor;
            mobius_mem[wr.addr[ADDR_W-1:0]] <= wr.mobius;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_factor <= factor_mem[rd_addr[ADDR_W-1:0]];
            rd_mobius <= mobius_mem[rd_addr[ADDR_W-1:0]];
        end
    end

endmodule

// File: hw/rtl/mls_prime_mem.sv
// List of primes found so far: one write port, one registered read port.
// Depends on mls_pkg for the integer width.
module mls_prime_mem #(
    parameter int PRIME_SLOTS = 32768
) (
    input  logic                               aclk,
    input  logic                               wr_en,
    input  logic [$clog2(PRIME_SLOTS)-1:0]     wr_addr,
    input  logic [mls_pkg::NUM_W-1:0]          wr_data,
    input  logic                               rd_en,
    input  logic [$clog2(PRIME_SLOTS)-1:0]     rd_addr,
    output logic [mls_pkg::NUM_W-1:0]          rd_data
);
    import mls_pkg::*;

    logic [NUM_W-1:0] prime_mem [PRIME_SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            prime_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= prime_mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/mobius_linear_sieve_unit.sv
// Mobius linear sieve unit. Integers 1, 2, 3, ... arrive on the s_ channel, one per
// transfer, and each yields one m_ result: its Mobius value, least prime factor, a prime
// flag and a status (out of order, or above the configured limit). After reset the unit
// clears its least-prime table, one entry per cycle, min(MAX_NUMBER, 262143) + 1 entries
// in all, with s_ready low. An in-order integer within the limit visits listed primes
// before the next transfer can happen, possibly running off the end of the prime list;
// each visit reads the prime list, multiplies, and compares and writes the tables, one
// step per cycle. A rejected integer skips the walk. A result held back by m_ready keeps
// the unit in its last step until the output register frees up. The user must write the
// limit through cfg_we / cfg_wdata only while no integer is in flight; the unit itself
// does not enforce this.
module mobius_linear_sieve_unit #(
    parameter int MAX_NUMBER  = 262143,
    parameter int PRIME_SLOTS = 32768
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [mls_pkg::NUM_W-1:0] cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [mls_pkg::NUM_W-1:0] s_number,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [mls_pkg::NUM_W-1:0] m_echo_number,
    output logic signed [1:0]         m_mobius,
    output logic [mls_pkg::NUM_W-1:0] m_least_prime,
    output logic                      m_is_prime,
    output logic [1:0]                m_status
);
    import mls_pkg::*;

    localparam int TOP    = (MAX_NUMBER < LIMIT_MAX) ? MAX_NUMBER : LIMIT_MAX;
    localparam int DEPTH  = TOP + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PIDX_W = $clog2(PRIME_SLOTS);
    localparam int CNT_W  = $clog2(PRIME_SLOTS + 1);
    localparam logic [NUM_W-1:0]  LIM_CAP   = NUM_W'(TOP);
    localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(PRIME_SLOTS);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [NUM_W-1:0]    limit_reg, limit_next;
    logic [NUM_W-1:0]    expected_reg, expected_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    z_reg, z_next;
    logic                m_valid_reg, m_valid_next;

    logic [NUM_W-1:0]    n_reg, n_next;
    logic [1:0]          status_reg, status_next;
    logic [NUM_W-1:0]    lp_reg, lp_next;
    logic [1:0]          mu_reg, mu_next;
    logic                prime_reg, prime_next;
    logic [NUM_W-1:0]    p_reg, p_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [NUM_W-1:0]    m_echo_reg, m_echo_next;
    logic [1:0]          m_mobius_reg, m_mobius_next;
    logic [NUM_W-1:0]    m_least_reg, m_least_next;
    logic                m_prime_reg, m_prime_next;
    logic [1:0]          m_status_reg, m_status_next;

    logic [NUM_W-1:0]    eff_lim;
    table_wr_t           tbl_wr;
    logic                tbl_rd_en;
    logic [NUM_W-1:0]    tbl_factor;
    logic [1:0]          tbl_mobius;
    logic                pl_wr_en;
    logic                pl_rd_en;
    logic [NUM_W-1:0]    pl_data;

    assign eff_lim = (limit_reg > LIM_CAP) ? LIM_CAP : limit_reg;

    mls_table_mem #(
        .DEPTH (DEPTH)
    ) u_table (
        .aclk      (aclk),
        .wr        (tbl_wr),
        .rd_en     (tbl_rd_en),
        .rd_addr   (s_number),
        .rd_factor (tbl_factor),
        .rd_mobius (tbl_mobius)
    );

    mls_prime_mem #(
        .PRIME_SLOTS (PRIME_SLOTS)
    ) u_primes (
        .aclk    (aclk),
        .wr_en   (pl_wr_en),
        .wr_addr (count_reg[PIDX_W-1:0]),
        .wr_data (n_reg),
        .rd_en   (pl_rd_en),
        .rd_addr (z_reg[PIDX_W-1:0]),
        .rd_data (pl_data)
    );

    // Table writes land at n * p, which is above n + 1 for every n that walks, and they
    // finish before the next integer is accepted, so the lookup never races a write.
    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        limit_next    = cfg_we ? cfg_wdata : limit_reg;
        expected_next = expected_reg;
        count_next    = count_reg;
        z_next        = z_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        n_next        = n_reg;
        status_next   = status_reg;
        lp_next       = lp_reg;
        mu_next       = mu_reg;
        prime_next    = prime_reg;
        p_next        = p_reg;
        prod_next     = prod_reg;
        m_echo_next   = m_echo_reg;
        m_mobius_next = m_mobius_reg;
        m_least_next  = m_least_reg;
        m_prime_next  = m_prime_reg;
        m_status_next = m_status_reg;
        tbl_wr        = '0;
        tbl_rd_en     = 1'b0;
        pl_wr_en      = 1'b0;
        pl_rd_en      = 1'b0;
        s_ready       = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                tbl_wr.en   = 1'b1;
                tbl_wr.addr = NUM_W'(clr_reg);
                if (clr_reg == CLR_LAST) begin
                    state_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE: begin
                s_ready   = 1'b1;
                tbl_rd_en = s_valid;
                if (s_valid) begin
                    n_next     = s_number;
                    lp_next    = '0;
                    mu_next    = MU_ZERO;
                    prime_next = 1'b0;
                    if (s_number == '0 || s_number != expected_reg) begin
                        status_next = ST_ORDER;
                        state_next  = S_FINISH;
                    end else if (s_number > eff_lim) begin
                        status_next = ST_LIMIT;
                        state_next  = S_FINISH;
                    end else begin
                        status_next = ST_OK;
                        state_next  = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                z_next     = '0;
                state_next = S_WALK_RD;
                if (n_reg == NUM_W'(1)) begin
                    lp_next = '0;
                    mu_next = MU_POS;
                end else if (tbl_factor == '0) begin
                    // Nothing smaller marked it, so it is prime.
                    lp_next    = n_reg;
                    mu_next    = MU_NEG;
                    prime_next = 1'b1;
                    if (count_reg < SLOTS_CNT) begin
                        pl_wr_en   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end else begin
                    lp_next = tbl_factor;
                    mu_next = tbl_mobius;
                end
            end
            S_WALK_RD: begin
                if (z_reg < count_reg) begin
                    pl_rd_en   = 1'b1;
                    state_next = S_WALK_MUL;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_WALK_MUL: begin
                p_next     = pl_data;
                prod_next  = PROD_W'(n_reg) * PROD_W'(pl_data);
                state_next = S_WALK_CMP;
            end
            S_WALK_CMP: begin
                if (prod_reg > PROD_W'(eff_lim)) begin
                    state_next = S_FINISH;
                end else begin
                    tbl_wr.en     = 1'b1;
                    tbl_wr.addr   = prod_reg[NUM_W-1:0];
                    tbl_wr.factor = p_reg;
                    if (p_reg == lp_reg) begin
                        tbl_wr.mobius = MU_ZERO;
                        state_next    = S_FINISH;
                    end else begin
                        tbl_wr.mobius = 2'(~mu_reg + 2'b01);
                        z_next        = z_reg + 1'b1;
                        state_next    = S_WALK_RD;
                    end
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_echo_next   = n_reg;
                    m_mobius_next = mu_reg;
                    m_least_next  = lp_reg;
                    m_prime_next  = prime_reg;
                    m_status_next = status_reg;
                    if (status_reg == ST_OK) begin
                        expected_next = n_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            limit_reg    <= NUM_W'(LIMIT_MAX);
            expected_reg <= NUM_W'(1);
            count_reg    <= '0;
            z_reg        <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            limit_reg    <= limit_next;
            expected_reg <= expected_next;
            count_reg    <= count_next;
            z_reg        <= z_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        status_reg   <= status_next;
        lp_reg       <= lp_next;
        mu_reg       <= mu_next;
        prime_reg    <= prime_next;
        p_reg        <= p_next;
        prod_reg     <= prod_next;
        m_echo_reg   <= m_echo_next;
        m_mobius_reg <= m_mobius_next;
        m_least_reg  <= m_least_next;
        m_prime_reg  <= m_prime_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_echo_number = m_echo_reg;
    assign m_mobius      = m_mobius_reg;
    assign m_least_prime = m_least_reg;
    assign m_is_prime    = m_prime_reg;
    assign m_status      = m_status_reg;

endmodule

// File: tb/sv/mobius_linear_sieve_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for mobius_linear_sieve_unit: directed rows, then random limits and
// mostly in-order integers, checked against a bench sieve or a row's own result. Needs mls_pkg.
module mobius_linear_sieve_unit_test;
    import mls_pkg::*;

    localparam int SIEVE_MAX   = 262143;
    localparam int SLOT_COUNT  = 32768;
    localparam int ITEM_COUNT  = 1250;
    localparam int RUN_LIMIT   = 4000000;
    localparam int TAIL_CYCLES = 40;
    localparam int ROW_COUNT   = 26;

    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic [1:0]       mobius;
        logic [NUM_W-1:0] least_prime;
        logic             is_prime;
        logic [1:0]       status;
    } sieve_result_t;

    typedef enum logic {ROW_ITEM, ROW_LIMIT} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [NUM_W-1:0] value;
        logic             typed;
        sieve_result_t    want;
    } dir_row_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_LONG} rx_mode_t;

    logic                      aclk;
    logic                      aresetn   = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [NUM_W-1:0]          cfg_wdata = '0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    logic [NUM_W-1:0]          s_number  = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    logic [NUM_W-1:0]          m_echo_number;
    logic signed [1:0]         m_mobius;
    logic [NUM_W-1:0]          m_least_prime;
    logic                      m_is_prime;
    logic [1:0]                m_status;

    // Bench copy of the sieve state.
    bit [NUM_W-1:0]   lpf_table [SIEVE_MAX+1];
    bit [1:0]         mu_table [SIEVE_MAX+1];
    bit [NUM_W-1:0]   found_primes [SLOT_COUNT];
    int unsigned      found_count = 0;
    logic [NUM_W-1:0] next_number = NUM_W'(1);
    logic [NUM_W-1:0] sieve_limit = NUM_W'(LIMIT_MAX);

    sieve_result_t awaited_results [$];
    int unsigned   err_count  = 0;
    int unsigned   burst_left = 0;
    logic [15:0]   rx_tick    = '0;
    rx_mode_t      rx_mode    = RX_ALWAYS;
    dir_row_t      directed_rows [ROW_COUNT];

    mobius_linear_sieve_unit #(
        .MAX_NUMBER  (SIEVE_MAX),
        .PRIME_SLOTS (SLOT_COUNT)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_number      (s_number),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_echo_number (m_echo_number),
        .m_mobius      (m_mobius),
        .m_least_prime (m_least_prime),
        .m_is_prime    (m_is_prime),
        .m_status      (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Classifies one accepted integer and advances the bench sieve exactly as the unit should.
    function automatic sieve_result_t classify_number(input logic [NUM_W-1:0] n);
        sieve_result_t     r;
        logic [PROD_W-1:0] prod;
        logic [NUM_W-1:0]  p;
        logic [1:0]        mu;
        logic              walk_done;
        int unsigned       z;
        r = '0;
        r.number = n;
        if (n == '0 || n != next_number) begin
            r.status = ST_ORDER;
        end else if (n > sieve_limit) begin
            r.status = ST_LIMIT;
        end else begin
            r.status = ST_OK;
            if (n == 1) begin
                mu_table[1] = MU_POS;
            end else if (lpf_table[n] == '0) begin
                lpf_table[n] = n;
                mu_table[n] = MU_NEG;
                r.is_prime = 1'b1;
                if (found_count < SLOT_COUNT) begin
                    found_primes[found_count] = n;
                    found_count++;
                end
            end
            r.least_prime = lpf_table[n];
            mu = mu_table[n];
            r.mobius = mu;
            walk_done = 1'b0;
            for (z = 0; z < found_count && !walk_done; z++) begin
                p = found_primes[z];
                prod = PROD_W'(n) * PROD_W'(p);
                if (prod > PROD_W'(sieve_limit)) begin
                    walk_done = 1'b1;
                end else begin
                    lpf_table[prod[NUM_W-1:0]] = p;
                    // At the least prime of n its square divides the product, and the walk ends.
                    if (p == r.least_prime) begin
                        mu_table[prod[NUM_W-1:0]] = MU_ZERO;
                        walk_done = 1'b1;
                    end else begin
                        mu_table[prod[NUM_W-1:0]] = -mu;
                    end
                end
            end
            next_number = n + 1'b1;
        end
        return r;
    endfunction

    task automatic offer_number(input logic [NUM_W-1:0] n, input logic typed,
                                input sieve_result_t typed_res);
        sieve_result_t res;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_number <= n;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        res = classify_number(n);
        if (typed) res = typed_res;
        awaited_results.push_back(res);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [NUM_W-1:0] value);
        wait_for_results();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sieve_limit = value;
    endtask

    // Result side: checks every transfer and stalls on a pattern that changes mode now and then.
    always @(posedge aclk) begin
        sieve_result_t got;
        sieve_result_t want;
        if (m_valid && m_ready) begin
            got = '{m_echo_number, m_mobius, m_least_prime, m_is_prime, m_status};
            if (awaited_results.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result: num %0d mu %0d lp %0d prime %0d st %0d",
                             got.number, got.mobius, got.least_prime, got.is_prime,
                             got.status);
            end else begin
                want = awaited_results.pop_front();
                if (got !== want) begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"mismatch: expected num %0d mu %0d lp %0d prime %0d st %0d,",
                                  " got num %0d mu %0d lp %0d prime %0d st %0d"},
                                 want.number, want.mobius, want.least_prime, want.is_prime,
                                 want.status, got.number, got.mobius, got.least_prime,
                                 got.is_prime, got.status);
                end
            end
        end
        rx_tick <= rx_tick + 1'b1;
        if (rx_tick[8:0] == '0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_ALWAYS: m_ready <= 1'b1;
            RX_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: m_ready <= (rx_tick[2:0] != 3'd0);
            default:   m_ready <= (rx_tick[4:0] > 5'd22);
        endcase
    end

    initial begin
        repeat (RUN_LIMIT) @(posedge aclk);
        $display("mobius_linear_sieve_unit_test NOT OK");
        $finish;
    end

    initial begin
        logic [NUM_W-1:0] pick;
        int unsigned      sel;
        int unsigned      phase_len;
        int unsigned      sent;

        directed_rows = '{
            '{ROW_ITEM, 18'd0, 1'b1, '{18'd0, MU_ZERO, 18'd0, 1'b0, ST_ORDER}},
            '{ROW_ITEM, 18'd2, 1'b1, '{18'd2, MU_ZERO, 18'd0, 1'b0, ST_ORDER}},
            '{ROW_ITEM, LIMIT_MAX[NUM_W-1:0], 1'b1,
              '{LIMIT_MAX[NUM_W-1:0], MU_ZERO, 18'd0, 1'b0, ST_ORDER}},
            '{ROW_ITEM, 18'd1, 1'b1, '{18'd1, MU_POS, 18'd0, 1'b0, ST_OK}},
            '{ROW_ITEM, 18'd2, 1'b1, '{18'd2, MU_NEG, 18'd2, 1'b1, ST_OK}},
            '{ROW_ITEM, 18'd3, 1'b0, '0},
            '{ROW_ITEM, 18'd4, 1'b1, '{18'd4, MU_ZERO, 18'd2, 1'b0, ST_OK}},
            '{ROW_ITEM, 18'd5, 1'b0, '0},
            '{ROW_ITEM, 18'd6, 1'b1, '{18'd6, MU_POS, 18'd2, 1'b0, ST_OK}},
            '{ROW_ITEM, 18'd7, 1'b0, '0},
            '{ROW_ITEM, 18'd9, 1'b1, '{18'd9, MU_ZERO, 18'd0, 1'b0, ST_ORDER}},
            '{ROW_ITEM, 18'd8, 1'b0, '0},
            '{ROW_ITEM, 18'd9, 1'b0, '0},
            '{ROW_ITEM, 18'd10, 1'b0, '0},
            '{ROW_LIMIT, 18'd1, 1'b0, '0},
            '{ROW_ITEM, 18'd11, 1'b1, '{18'd11, MU_ZERO, 18'd0, 1'b0, ST_LIMIT}},
            // The order check wins over the limit check.
            '{ROW_ITEM, 18'd12, 1'b1, '{18'd12, MU_ZERO, 18'd0, 1'b0, ST_ORDER}},
            '{ROW_LIMIT, LIMIT_MAX[NUM_W-1:0], 1'b0, '0},
            '{ROW_ITEM, 18'd11, 1'b0, '0},
            '{ROW_ITEM, 18'd12, 1'b0, '0},
            '{ROW_ITEM, 18'd13, 1'b0, '0},
            '{ROW_ITEM, 18'd14, 1'b0, '0},
            '{ROW_ITEM, 18'd15, 1'b0, '0},
            '{ROW_ITEM, 18'd16, 1'b0, '0},
            '{ROW_ITEM, 18'd17, 1'b0, '0},
            '{ROW_ITEM, 18'd18, 1'b0, '0}
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_LIMIT)
                write_limit(directed_rows[i].value);
            else
                offer_number(directed_rows[i].value, directed_rows[i].typed,
                             directed_rows[i].want);
        end

        // Random phases: a new limit, then a run of mostly in-order integers with some noise.
        sent = 0;
        while (sent < ITEM_COUNT) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0:       pick = 18'd1;
                1:       pick = NUM_W'(LIMIT_MAX);
                2:       pick = NUM_W'($urandom_range(1, LIMIT_MAX));
                3:       pick = (next_number > 2) ? NUM_W'($urandom_range(1, next_number - 1))
                                                  : 18'd1;
                default: pick = NUM_W'(next_number + $urandom_range(0, 150));
            endcase
            write_limit(pick);
            phase_len = (sel == 0 || sel == 3) ? $urandom_range(5, 20)
                                               : $urandom_range(20, 120);
            repeat (phase_len) begin
                sel = $urandom_range(0, 19);
                case (sel)
                    0:       pick = NUM_W'($urandom_range(0, LIMIT_MAX));
                    1:       pick = '0;
                    2:       pick = NUM_W'(next_number + $urandom_range(1, 3));
                    3:       pick = next_number - 1'b1;
                    default: pick = next_number;
                endcase
                offer_number(pick, 1'b0, '0);
                sent++;
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("mobius_linear_sieve_unit_test OK");
        else
            $display("mobius_linear_sieve_unit_test NOT OK");
        $finish;
    end

endmodule

// File: mobius_linear_sieve_unit.f
hw/rtl/mls_pkg.sv
hw/rtl/mls_table_mem.sv
hw/rtl/mls_prime_mem.sv
hw/rtl/mobius_linear_sieve_unit.sv
tb/sv/mobius_linear_sieve_unit_test.sv
